### rtl/assert_macros.svh
// Assertion macros used by the checker in bpm_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is active (active-low reset).
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Clocked assertion that a condition never holds.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  `ASSERT_CLK(label, clk, rst_n, !(cond))

`endif

### rtl/bpm_pkg.sv
// Package for the brace pair matcher: types, codes and character constants.
package bpm_pkg;

  localparam int unsigned ORD_W   = 16;
  localparam int unsigned POS_W   = 21;
  localparam int unsigned START_W = 20;
  localparam int unsigned EV_W    = 3;

  localparam logic [7:0] CH_OPEN   = 8'h7B;
  localparam logic [7:0] CH_CLOSE  = 8'h7D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [EV_W-1:0] {
    EV_OTHER     = 3'd0,
    EV_OPEN      = 3'd1,
    EV_MATCH     = 3'd2,
    EV_UNMATCHED = 3'd3,
    EV_OVERFLOW  = 3'd4
  } bpm_event_e;

  typedef struct packed {
    logic push;
    logic pop;
  } bpm_shift_t;

  typedef struct packed {
    bpm_event_e        event_res;
    logic [POS_W-1:0]  position;
    logic [ORD_W-1:0]  left_ordinal;
    logic              done_res;
    logic [ORD_W-1:0]  pair_count;
    logic              failed;
  } bpm_result_t;

endpackage

### rtl/bpm_cell.sv
// One stack cell: holds an ordinal and shifts toward or away from the top.
module bpm_cell (
  input  logic                       clk_i,
  input  bpm_pkg::bpm_shift_t        ctrl_i,
  input  logic [bpm_pkg::ORD_W-1:0]  above_i,
  input  logic [bpm_pkg::ORD_W-1:0]  below_i,
  output logic [bpm_pkg::ORD_W-1:0]  entry_o
);

  logic [bpm_pkg::ORD_W-1:0] entry_d, entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.push) begin
      entry_d = above_i;
    end else if (ctrl_i.pop) begin
      entry_d = below_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

### rtl/bpm_out_buf.sv
// Two-entry output buffer: output register plus skid register.
module bpm_out_buf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  bpm_pkg::bpm_result_t  res_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output bpm_pkg::bpm_result_t  res_o,
  output logic                  full_o
);

  logic                 out_vld_d, out_vld_q;
  logic                 skid_vld_d, skid_vld_q;
  bpm_pkg::bpm_result_t out_d, out_q;
  bpm_pkg::bpm_result_t skid_d, skid_q;
  logic                 out_fire;

  assign out_fire = out_vld_q && !out_stall_i;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (skid_vld_q) begin
      if (out_fire) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_vld_q || out_fire) begin
        out_d     = res_i;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = res_i;
        skid_vld_d = 1'b1;
      end
    end else if (out_fire) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_vld_q;
  assign res_o       = out_q;
  assign full_o      = skid_vld_q;

endmodule

### rtl/brace_pair_matcher.sv
// Top level of the brace pair matcher.
// Takes one character per clock while in_stall_o is low and gives one result per
// character. The open-brace stack is a row of STACK_DEPTH shift cells whose top sits
// in the first cell, so a push or pop completes in the same cycle as its character
// and the next character may follow at once. Results leave through a two-entry
// buffer; in_stall_o rises only when both entries hold results that the output side
// has not taken. Sustained rate is one character per cycle with out_stall_i low.
module brace_pair_matcher #(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned CHAR_BITS   = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bpm_pkg::START_W-1:0]  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [CHAR_BITS-1:0]         char_code_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bpm_pkg::EV_W-1:0]     event_res_o,
  output logic [bpm_pkg::POS_W-1:0]    position_o,
  output logic [bpm_pkg::ORD_W-1:0]    left_ordinal_o,
  output logic                         done_res_o,
  output logic [bpm_pkg::ORD_W-1:0]    pair_count_o,
  output logic                         failed_o
);

  localparam int unsigned DEPTH_W = $clog2(STACK_DEPTH + 1);
  localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(STACK_DEPTH);

  logic [bpm_pkg::START_W-1:0] start_q;
  logic [DEPTH_W-1:0]          depth_d, depth_q;
  logic [bpm_pkg::ORD_W-1:0]   left_cnt_d, left_cnt_q;
  logic [bpm_pkg::POS_W-1:0]   offset_d, offset_q;
  logic                        prev_bs_d, prev_bs_q;
  logic                        fail_d, fail_q;

  logic                        accept, live, is_open, is_close, is_bs, full, empty;
  logic                        do_push, do_pop, overflow, unmatched, done_failed;
  logic                        buf_full;
  bpm_pkg::bpm_shift_t         shift;
  bpm_pkg::bpm_result_t        res, res_out;
  logic [bpm_pkg::ORD_W-1:0]   entry [STACK_DEPTH];

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = buf_full;
  assign accept      = in_valid_i && !in_stall_o;

  assign is_open  = char_code_i == CHAR_BITS'(bpm_pkg::CH_OPEN);
  assign is_close = char_code_i == CHAR_BITS'(bpm_pkg::CH_CLOSE);
  assign is_bs    = char_code_i == CHAR_BITS'(bpm_pkg::CH_BSLASH);
  assign live     = !prev_bs_q && !fail_q;
  assign full     = depth_q == DEPTH_FULL;
  assign empty    = depth_q == '0;

  assign do_push   = accept && live && is_open && !full;
  assign overflow  = live && is_open && full;
  assign do_pop    = accept && live && is_close && !empty;
  assign unmatched = live && is_close && empty;

  assign shift.push = do_push;
  assign shift.pop  = do_pop;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [bpm_pkg::ORD_W-1:0] above, below;
    if (i == 0) begin : g_top
      assign above = left_cnt_q;
    end else begin : g_mid
      assign above = entry[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_end
      assign below = '0;
    end else begin : g_inner
      assign below = entry[i+1];
    end
    bpm_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (shift),
      .above_i (above),
      .below_i (below),
      .entry_o (entry[i])
    );
  end

  always_comb begin
    depth_d    = depth_q;
    left_cnt_d = left_cnt_q;
    fail_d     = fail_q || overflow || unmatched;
    if (do_push) begin
      depth_d    = depth_q + 1'b1;
      left_cnt_d = left_cnt_q + 1'b1;
    end else if (do_pop) begin
      depth_d = depth_q - 1'b1;
    end
    offset_d  = offset_q + 1'b1;
    prev_bs_d = is_bs;
  end

  assign done_failed = fail_d || (depth_d != '0);

  always_comb begin
    res.event_res    = bpm_pkg::EV_OTHER;
    res.left_ordinal = '0;
    if (do_push) begin
      res.event_res    = bpm_pkg::EV_OPEN;
      res.left_ordinal = left_cnt_q;
    end else if (do_pop) begin
      res.event_res    = bpm_pkg::EV_MATCH;
      res.left_ordinal = entry[0];
    end else if (overflow) begin
      res.event_res = bpm_pkg::EV_OVERFLOW;
    end else if (unmatched) begin
      res.event_res = bpm_pkg::EV_UNMATCHED;
    end
    res.position   = bpm_pkg::POS_W'(start_q) + offset_q;
    res.done_res   = last_i;
    res.pair_count = (last_i && !done_failed) ? left_cnt_d : '0;
    res.failed     = last_i && done_failed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q    <= '0;
      depth_q    <= '0;
      left_cnt_q <= '0;
      offset_q   <= '0;
      prev_bs_q  <= 1'b0;
      fail_q     <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        start_q <= cfg_data_i;
      end
      if (accept) begin
        if (last_i) begin
          depth_q    <= '0;
          left_cnt_q <= '0;
          offset_q   <= '0;
          prev_bs_q  <= 1'b0;
          fail_q     <= 1'b0;
        end else begin
          depth_q    <= depth_d;
          left_cnt_q <= left_cnt_d;
          offset_q   <= offset_d;
          prev_bs_q  <= prev_bs_d;
          fail_q     <= fail_d;
        end
      end
    end
  end

  bpm_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res_out),
    .full_o      (buf_full)
  );

  assign event_res_o    = res_out.event_res;
  assign position_o     = res_out.position;
  assign left_ordinal_o = res_out.left_ordinal;
  assign done_res_o     = res_out.done_res;
  assign pair_count_o   = res_out.pair_count;
  assign failed_o       = res_out.failed;

endmodule

### rtl/bpm_checker.sv
// Port-level checker for the brace pair matcher, bound to the top level.
`include "assert_macros.svh"

module bpm_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [bpm_pkg::EV_W-1:0]     event_res_o,
  input logic [bpm_pkg::POS_W-1:0]    position_o,
  input logic [bpm_pkg::ORD_W-1:0]    left_ordinal_o,
  input logic                         done_res_o,
  input logic [bpm_pkg::ORD_W-1:0]    pair_count_o,
  input logic                         failed_o
);

  `ASSERT_CLK(a_fail_only_on_done, clk_i, rst_ni,
    out_valid_o && failed_o |-> done_res_o)

  `ASSERT_CLK(a_pairs_only_on_clean_done, clk_i, rst_ni,
    out_valid_o && (pair_count_o != '0) |-> done_res_o && !failed_o)

  `ASSERT_CLK(a_ordinal_only_on_brace, clk_i, rst_ni,
    out_valid_o && (left_ordinal_o != '0) |->
      (event_res_o == bpm_pkg::EV_OPEN) || (event_res_o == bpm_pkg::EV_MATCH))

  `ASSERT_CLK(a_stalled_result_holds, clk_i, rst_ni,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(position_o)
      && $stable(event_res_o))

endmodule

bind brace_pair_matcher bpm_checker u_bpm_checker (.*);
